>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the timer bank RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define STB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define STB_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Types and constants shared by the timer bank modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

  localparam int COUNT_W = 16;
  localparam int TAG_W   = 3;
  localparam int TIDX_W  = 4;
  localparam int OPC_W   = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_STOP   = 2'd2,
    OP_RESUME = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_RUNNING = 2'd1,
    ST_DONE    = 2'd2
  } status_e;

  // One timer entry as held in the store.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] reload;
    status_e            status;
    logic [TAG_W-1:0]   tag;
    logic               repeat_mode;
  } entry_t;

  // Scan engine to result stage.
  typedef struct packed {
    logic              hit;
    logic              flush;
    logic [TIDX_W-1:0] index;
    logic [TAG_W-1:0]  service;
  } res_ctl_t;

endpackage

>>> hw/rtl/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of 16-bit down-counting timers kept in a single entry store.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   opcode_i selects tick, set, stop or resume; set and the stop/resume
//   pair address timer_index_i, and indexes past the bank are ignored.
//   Set writes the entry in the accept cycle and the next command can be
//   taken in the following cycle. Stop and resume read, patch and write
//   back the entry, so busy stays high for one cycle.
//   Tick walks the store one timer per cycle: read address n, and in the
//   following cycle decrement, reload or retire timer n and write it back.
//   busy stays high for the whole walk, which the store's single read
//   port paces.
//   Each expiry yields one result transaction, in timer order, shown for
//   one cycle with result_valid_o. One expiry is held back until the next
//   one (or the end of the walk) is known, so last_o marks the final one.
//   The final result of a tick is shown in the cycle in which busy falls.
//   A tick with no expiry yields nothing; other commands never do.
//   The receiver has no way to stall results.
//   Reset clears all control state; every timer reads as zero and off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module software_timer_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [stb_pkg::OPC_W-1:0]     opcode_i,
  input  logic [stb_pkg::TIDX_W-1:0]    timer_index_i,
  input  logic [stb_pkg::COUNT_W-1:0]   load_value_i,
  input  logic [stb_pkg::TAG_W-1:0]     service_tag_i,
  input  logic                          periodic_i,
  output logic                          result_valid_o,
  output logic [stb_pkg::TIDX_W-1:0]    expired_index_o,
  output logic [stb_pkg::TAG_W-1:0]     expired_service_o,
  output logic                          last_o
);

  // one-hot sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RMW  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [stb_pkg::CNT_W-1:0]   rd_cnt_q, rd_cnt_d;   // next address to read
  logic                        proc_q;               // read data due this cycle
  logic [stb_pkg::IDX_W-1:0]   proc_idx_q;
  stb_pkg::opcode_e            op_q;
  logic [stb_pkg::IDX_W-1:0]   op_idx_q;

  logic                        accept;
  stb_pkg::opcode_e            op;
  logic                        idx_ok;

  logic                        rd_en;
  logic [stb_pkg::IDX_W-1:0]   rd_addr;
  stb_pkg::entry_t             rd_data;
  logic                        wr_en;
  logic [stb_pkg::IDX_W-1:0]   wr_addr;
  stb_pkg::entry_t             wr_data;
  stb_pkg::entry_t             upd;
  stb_pkg::res_ctl_t           res_ctl;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign op     = stb_pkg::opcode_e'(opcode_i);
  // timers past the bank size are never touched
  assign idx_ok = ({4'b0000, timer_index_i} < 8'(stb_pkg::NUM_TIMERS));

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    upd      = rd_data;
    wr_data  = rd_data;
    res_ctl  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            stb_pkg::OP_TICK: begin
              rd_cnt_d = '0;
              state_d  = S_SCAN;
            end
            stb_pkg::OP_SET: begin
              if (idx_ok) begin
                wr_en               = 1'b1;
                wr_addr             = stb_pkg::IDX_W'(timer_index_i);
                wr_data.count       = load_value_i;
                wr_data.reload      = load_value_i;
                wr_data.status      = stb_pkg::ST_RUNNING;
                wr_data.tag         = service_tag_i;
                wr_data.repeat_mode = periodic_i;
              end
            end
            stb_pkg::OP_STOP, stb_pkg::OP_RESUME: begin
              if (idx_ok) begin
                rd_en   = 1'b1;
                rd_addr = stb_pkg::IDX_W'(timer_index_i);
                state_d = S_RMW;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        // patch only the run status, keep count and reload
        wr_en          = 1'b1;
        wr_addr        = op_idx_q;
        wr_data.status = (op_q == stb_pkg::OP_STOP) ? stb_pkg::ST_OFF
                                                    : stb_pkg::ST_RUNNING;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        if (rd_cnt_q < stb_pkg::CNT_W'(stb_pkg::NUM_TIMERS)) begin
          rd_en    = 1'b1;
          rd_addr  = stb_pkg::IDX_W'(rd_cnt_q);
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (proc_q && (rd_data.status == stb_pkg::ST_RUNNING)) begin
          // zero wraps to all ones and does not expire this tick
          upd.count = rd_data.count - 16'd1;
          if (upd.count == '0) begin
            res_ctl.hit     = 1'b1;
            res_ctl.index   = stb_pkg::TIDX_W'(proc_idx_q);
            res_ctl.service = rd_data.tag;
            if (rd_data.repeat_mode) begin
              upd.count = rd_data.reload;
            end else begin
              upd.status = stb_pkg::ST_DONE;
            end
          end
          wr_en   = 1'b1;
          wr_addr = proc_idx_q;
          wr_data = upd;
        end
        // walk finished: release the held expiry as the last one
        if (!rd_en && !proc_q) begin
          res_ctl.flush = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_cnt_q <= '0;
      proc_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      proc_q   <= (state_q == S_SCAN) && rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= rd_addr;
    if (accept) begin
      op_q     <= op;
      op_idx_q <= stb_pkg::IDX_W'(timer_index_i);
    end
  end

  stb_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  stb_result u_result (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (res_ctl),
    .result_valid_o    (result_valid_o),
    .expired_index_o   (expired_index_o),
    .expired_service_o (expired_service_o),
    .last_o            (last_o)
  );

  `STB_ASSERT(a_cmd_no_result, clk_i, rst_ni,
              (accept && (op != stb_pkg::OP_TICK)) |=> !result_valid_o)
  `STB_ASSERT(a_last_then_quiet, clk_i, rst_ni,
              (result_valid_o && last_o) |=> !result_valid_o)
  `STB_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni,
                    rd_cnt_q > stb_pkg::CNT_W'(stb_pkg::NUM_TIMERS))

endmodule

>>> hw/rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Timer entry store: one write and one read port, registered read data.
// Entries never written read back as all zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stb_ram (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [stb_pkg::IDX_W-1:0] rd_addr_i,
  output stb_pkg::entry_t          rd_data_o,
  input  logic                     wr_en_i,
  input  logic [stb_pkg::IDX_W-1:0] wr_addr_i,
  input  stb_pkg::entry_t          wr_data_i
);

  stb_pkg::entry_t                  mem_q [stb_pkg::NUM_TIMERS];
  stb_pkg::entry_t                  rd_raw_q;
  logic [stb_pkg::NUM_TIMERS-1:0]   valid_q;
  logic                             rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry written flags stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_ok_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_ok_q ? rd_raw_q : '0;

  `STB_ASSERT_NEVER(a_no_same_addr_rw, clk_i, rst_ni,
                    rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i))

endmodule

>>> hw/rtl/stb_result.sv
// ----------------------------------------------------------------------------
// stb_result
// Holds back one expiry so the final one of a tick can carry last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stb_result (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  stb_pkg::res_ctl_t           ctl_i,
  output logic                        result_valid_o,
  output logic [stb_pkg::TIDX_W-1:0]  expired_index_o,
  output logic [stb_pkg::TAG_W-1:0]   expired_service_o,
  output logic                        last_o
);

  logic                       pend_q;
  logic [stb_pkg::TIDX_W-1:0] pend_idx_q;
  logic [stb_pkg::TAG_W-1:0]  pend_svc_q;
  logic                       out_vld_q;
  logic [stb_pkg::TIDX_W-1:0] out_idx_q;
  logic [stb_pkg::TAG_W-1:0]  out_svc_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= pend_q && (ctl_i.hit || ctl_i.flush);
      if (ctl_i.hit) begin
        pend_q <= 1'b1;
      end else if (ctl_i.flush) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.hit || ctl_i.flush) begin
      out_idx_q  <= pend_idx_q;
      out_svc_q  <= pend_svc_q;
      out_last_q <= ctl_i.flush;
    end
    if (ctl_i.hit) begin
      pend_idx_q <= ctl_i.index;
      pend_svc_q <= ctl_i.service;
    end
  end

  assign result_valid_o    = out_vld_q;
  assign expired_index_o   = out_idx_q;
  assign expired_service_o = out_svc_q;
  assign last_o            = out_last_q;

endmodule
